### rtl/core/swept_aabb_time_of_impact_unit_defines.svh
// Assertion macros for the swept box time of impact unit.
// Included by the top level; depends on nothing else.
`ifndef SWEPT_AABB_TIME_OF_IMPACT_UNIT_DEFINES_SVH
`define SWEPT_AABB_TIME_OF_IMPACT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SWAABB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define SWAABB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/swaabb_pkg.sv
// Shared widths, the interval reset value and payload types of the swept box unit.
// No dependencies.
package swaabb_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int TIME_WIDTH  = 32;
	localparam logic [TIME_WIDTH-1:0] TOTAL_TIME_RESET = TIME_WIDTH'(65536);

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] a_low_x;
		logic signed [COORD_WIDTH-1:0] a_low_z;
		logic signed [COORD_WIDTH-1:0] a_high_x;
		logic signed [COORD_WIDTH-1:0] a_high_z;
		logic signed [COORD_WIDTH-1:0] b_low_x;
		logic signed [COORD_WIDTH-1:0] b_low_z;
		logic signed [COORD_WIDTH-1:0] b_high_x;
		logic signed [COORD_WIDTH-1:0] b_high_z;
		logic signed [COORD_WIDTH-1:0] a_move_x;
		logic signed [COORD_WIDTH-1:0] a_move_z;
		logic signed [COORD_WIDTH-1:0] b_move_x;
		logic signed [COORD_WIDTH-1:0] b_move_z;
	} swaabb_in_t;

	typedef struct packed {
		logic                  collided;
		logic [TIME_WIDTH-1:0] hit_time;
	} swaabb_out_t;

endpackage

### rtl/core/swept_aabb_time_of_impact_unit.sv
// Swept box time of impact unit: top level and whole datapath.
// Depends on swaabb_pkg and swept_aabb_time_of_impact_unit_defines.svh.
// Pipeline: nine geometry stages, one scaling multiply stage, 32 restoring
// divider stages. Throughput: one box pair per cycle while no result waits
// on out_stall; the 32-stage pipelined divider sets depth.
// Reset (arst_n low, asynchronous): all stage valids clear, total_time = 1.0.
`include "swept_aabb_time_of_impact_unit_defines.svh"

module swept_aabb_time_of_impact_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  swaabb_pkg::swaabb_in_t                in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output swaabb_pkg::swaabb_out_t               out_data,
	input  logic                                  cfg_wr_en,
	input  logic [swaabb_pkg::TIME_WIDTH-1:0]     cfg_wr_data
);

	localparam int CW  = swaabb_pkg::COORD_WIDTH;
	localparam int TW  = swaabb_pkg::TIME_WIDTH;
	localparam int EW  = CW + 1;        // Minkowski edges and relative motion
	localparam int NXW = CW + 2;        // signed headroom for negation
	localparam int PW  = NXW + EW;      // edge span products
	localparam int XW  = 2 * EW;        // fraction cross products
	localparam int NW  = EW + TW;       // n * total_time

	// Interval length register.
	logic [TW-1:0] total_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_time_q <= swaabb_pkg::TOTAL_TIME_RESET;
		end else if (cfg_wr_en) begin
			total_time_q <= cfg_wr_data;
		end
	end

	// The whole pipe advances together; hold everything while a finished result
	// waits at the output. Bubbles still move, so one transfer per cycle holds.
	logic ce;
	assign ce       = !(out_valid && out_stall);
	assign in_stall = !ce;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic div_v_s [0:TW];

	// ---------------------------------------------------------------- stage 1
	// Sort corners per axis and form relative motion m = b_move - a_move.
	logic signed [CW-1:0] alx_s1, ahx_s1, alz_s1, ahz_s1;
	logic signed [CW-1:0] blx_s1, bhx_s1, blz_s1, bhz_s1;
	logic signed [EW-1:0] mx_s1, mz_s1;

	always_ff @(posedge clk) begin
		if (ce) begin
			alx_s1 <= (in_data.a_low_x < in_data.a_high_x) ? in_data.a_low_x : in_data.a_high_x;
			ahx_s1 <= (in_data.a_low_x < in_data.a_high_x) ? in_data.a_high_x : in_data.a_low_x;
			alz_s1 <= (in_data.a_low_z < in_data.a_high_z) ? in_data.a_low_z : in_data.a_high_z;
			ahz_s1 <= (in_data.a_low_z < in_data.a_high_z) ? in_data.a_high_z : in_data.a_low_z;
			blx_s1 <= (in_data.b_low_x < in_data.b_high_x) ? in_data.b_low_x : in_data.b_high_x;
			bhx_s1 <= (in_data.b_low_x < in_data.b_high_x) ? in_data.b_high_x : in_data.b_low_x;
			blz_s1 <= (in_data.b_low_z < in_data.b_high_z) ? in_data.b_low_z : in_data.b_high_z;
			bhz_s1 <= (in_data.b_low_z < in_data.b_high_z) ? in_data.b_high_z : in_data.b_low_z;
			mx_s1  <= $signed({in_data.b_move_x[CW-1], in_data.b_move_x})
				- $signed({in_data.a_move_x[CW-1], in_data.a_move_x});
			mz_s1  <= $signed({in_data.b_move_z[CW-1], in_data.b_move_z})
				- $signed({in_data.a_move_z[CW-1], in_data.a_move_z});
		end
	end

	// ---------------------------------------------------------------- stage 2
	// Minkowski difference D = A - B.
	logic signed [EW-1:0] dlx_s2, dhx_s2, dlz_s2, dhz_s2, mx_s2, mz_s2;

	always_ff @(posedge clk) begin
		if (ce) begin
			dlx_s2 <= $signed({alx_s1[CW-1], alx_s1}) - $signed({bhx_s1[CW-1], bhx_s1});
			dhx_s2 <= $signed({ahx_s1[CW-1], ahx_s1}) - $signed({blx_s1[CW-1], blx_s1});
			dlz_s2 <= $signed({alz_s1[CW-1], alz_s1}) - $signed({bhz_s1[CW-1], bhz_s1});
			dhz_s2 <= $signed({ahz_s1[CW-1], ahz_s1}) - $signed({blz_s1[CW-1], blz_s1});
			mx_s2  <= mx_s1;
			mz_s2  <= mz_s1;
		end
	end

	// ---------------------------------------------------------------- stage 3
	// Per edge: fold the motion sign into numerator n and denominator d and
	// drop edges that are parallel or crossed outside t in [0,1].
	logic signed [EW-1:0] e_c     [4];
	logic signed [EW-1:0] e_along [4];
	logic signed [EW-1:0] e_cross [4];
	logic signed [EW-1:0] e_lo    [4];
	logic signed [EW-1:0] e_hi    [4];

	assign e_c[0] = dlx_s2; assign e_along[0] = mx_s2; assign e_cross[0] = mz_s2;
	assign e_c[1] = dhx_s2; assign e_along[1] = mx_s2; assign e_cross[1] = mz_s2;
	assign e_c[2] = dlz_s2; assign e_along[2] = mz_s2; assign e_cross[2] = mx_s2;
	assign e_c[3] = dhz_s2; assign e_along[3] = mz_s2; assign e_cross[3] = mx_s2;
	assign e_lo[0] = dlz_s2; assign e_hi[0] = dhz_s2;
	assign e_lo[1] = dlz_s2; assign e_hi[1] = dhz_s2;
	assign e_lo[2] = dlx_s2; assign e_hi[2] = dhx_s2;
	assign e_lo[3] = dlx_s2; assign e_hi[3] = dhx_s2;

	logic                 ok_s3    [4];
	logic        [EW-1:0] n_s3     [4];
	logic        [EW-1:0] d_s3     [4];
	logic signed [EW-1:0] cross_s3 [4];
	logic signed [EW-1:0] lo_s3    [4];
	logic signed [EW-1:0] hi_s3    [4];

	logic                 ok_s4 [4];
	logic        [EW-1:0] n_s4  [4];
	logic        [EW-1:0] d_s4  [4];
	logic signed [PW-1:0] p_s4  [4];
	logic signed [PW-1:0] pl_s4 [4];
	logic signed [PW-1:0] ph_s4 [4];

	logic          hit_s5 [4];
	logic [EW-1:0] n_s5   [4];
	logic [EW-1:0] d_s5   [4];

	logic          hit_s6 [4];
	logic [EW-1:0] n_s6   [4];
	logic [EW-1:0] d_s6   [4];

	for (genvar e = 0; e < 4; e++) begin : g_edge
		logic signed [NXW-1:0] c_x, a_x, nx, dx;
		logic signed [NXW-1:0] n_sg, d_sg;

		assign c_x  = $signed({e_c[e][EW-1], e_c[e]});
		assign a_x  = $signed({e_along[e][EW-1], e_along[e]});
		assign nx   = e_along[e][EW-1] ? -c_x : c_x;
		assign dx   = e_along[e][EW-1] ? -a_x : a_x;
		assign n_sg = $signed({1'b0, n_s3[e]});
		assign d_sg = $signed({1'b0, d_s3[e]});

		always_ff @(posedge clk) begin
			if (ce) begin
				// stage 3
				ok_s3[e]    <= (e_along[e] != '0) && !nx[NXW-1] && (nx <= dx);
				n_s3[e]     <= nx[EW-1:0];
				d_s3[e]     <= dx[EW-1:0];
				cross_s3[e] <= e_cross[e];
				lo_s3[e]    <= e_lo[e];
				hi_s3[e]    <= e_hi[e];
				// stage 4: crossing point against the edge span, scaled by d
				ok_s4[e] <= ok_s3[e];
				n_s4[e]  <= n_s3[e];
				d_s4[e]  <= d_s3[e];
				p_s4[e]  <= n_sg * cross_s3[e];
				pl_s4[e] <= lo_s3[e] * d_sg;
				ph_s4[e] <= hi_s3[e] * d_sg;
				// stage 5: inclusive span test
				hit_s5[e] <= ok_s4[e] && (pl_s4[e] <= p_s4[e]) && (p_s4[e] <= ph_s4[e]);
				n_s5[e]   <= n_s4[e];
				d_s5[e]   <= d_s4[e];
				// stage 6 carries
				hit_s6[e] <= hit_s5[e];
				n_s6[e]   <= n_s5[e];
				d_s6[e]   <= d_s5[e];
			end
		end
	end

	// ---------------------------------------------------------------- stage 6
	// Cross products to compare fractions n/d within the pairs (0,1), (2,3).
	logic [XW-1:0] x01_s6, x10_s6, x23_s6, x32_s6;

	always_ff @(posedge clk) begin
		if (ce) begin
			x01_s6 <= n_s5[0] * d_s5[1];
			x10_s6 <= n_s5[1] * d_s5[0];
			x23_s6 <= n_s5[2] * d_s5[3];
			x32_s6 <= n_s5[3] * d_s5[2];
		end
	end

	// ---------------------------------------------------------------- stage 7
	// Keep the earlier edge of each pair; on a tie keep the first.
	logic          sel1, sel3;
	logic          w0_hit_s7, w1_hit_s7;
	logic [EW-1:0] w0_n_s7, w0_d_s7, w1_n_s7, w1_d_s7;

	assign sel1 = hit_s6[1] && (!hit_s6[0] || (x10_s6 < x01_s6));
	assign sel3 = hit_s6[3] && (!hit_s6[2] || (x32_s6 < x23_s6));

	always_ff @(posedge clk) begin
		if (ce) begin
			w0_hit_s7 <= hit_s6[0] || hit_s6[1];
			w0_n_s7   <= sel1 ? n_s6[1] : n_s6[0];
			w0_d_s7   <= sel1 ? d_s6[1] : d_s6[0];
			w1_hit_s7 <= hit_s6[2] || hit_s6[3];
			w1_n_s7   <= sel3 ? n_s6[3] : n_s6[2];
			w1_d_s7   <= sel3 ? d_s6[3] : d_s6[2];
		end
	end

	// ---------------------------------------------------------------- stage 8
	logic          w0_hit_s8, w1_hit_s8;
	logic [EW-1:0] w0_n_s8, w0_d_s8, w1_n_s8, w1_d_s8;
	logic [XW-1:0] y_s8, z_s8;

	always_ff @(posedge clk) begin
		if (ce) begin
			w0_hit_s8 <= w0_hit_s7;
			w0_n_s8   <= w0_n_s7;
			w0_d_s8   <= w0_d_s7;
			w1_hit_s8 <= w1_hit_s7;
			w1_n_s8   <= w1_n_s7;
			w1_d_s8   <= w1_d_s7;
			y_s8      <= w1_n_s7 * w0_d_s7;
			z_s8      <= w0_n_s7 * w1_d_s7;
		end
	end

	// ---------------------------------------------------------------- stage 9
	// Final pick. A miss becomes 0/1 so the divider returns zero.
	logic          selw1, found;
	logic          found_s9;
	logic [EW-1:0] n_s9, d_s9;

	assign selw1 = w1_hit_s8 && (!w0_hit_s8 || (y_s8 < z_s8));
	assign found = w0_hit_s8 || w1_hit_s8;

	always_ff @(posedge clk) begin
		if (ce) begin
			found_s9 <= found;
			n_s9     <= !found ? '0 : (selw1 ? w1_n_s8 : w0_n_s8);
			d_s9     <= !found ? EW'(1) : (selw1 ? w1_d_s8 : w0_d_s8);
		end
	end

	// ---------------------------------------------------------- divider stages
	// Entry stage forms n * total_time; each later stage retires one quotient
	// bit by restoring division. Since n <= d the quotient fits TW bits.
	logic [NW-1:0] num;
	logic [EW-1:0] div_rem_s   [0:TW];
	logic [TW-1:0] div_low_s   [0:TW];
	logic [TW-1:0] div_q_s     [0:TW];
	logic [EW-1:0] div_d_s     [0:TW];
	logic          div_found_s [0:TW];

	assign num = n_s9 * total_time_q;

	always_ff @(posedge clk) begin
		if (ce) begin
			div_rem_s[0]   <= num[NW-1:TW];
			div_low_s[0]   <= num[TW-1:0];
			div_q_s[0]     <= '0;
			div_d_s[0]     <= d_s9;
			div_found_s[0] <= found_s9;
		end
	end

	for (genvar k = 1; k <= TW; k++) begin : g_div
		logic [EW:0] trial, diff;
		logic        take;

		assign trial = {div_rem_s[k-1], div_low_s[k-1][TW-1]};
		assign diff  = trial - {1'b0, div_d_s[k-1]};
		assign take  = trial >= {1'b0, div_d_s[k-1]};

		always_ff @(posedge clk) begin
			if (ce) begin
				div_rem_s[k]   <= take ? diff[EW-1:0] : trial[EW-1:0];
				div_low_s[k]   <= {div_low_s[k-1][TW-2:0], 1'b0};
				div_q_s[k]     <= {div_q_s[k-1][TW-2:0], take};
				div_d_s[k]     <= div_d_s[k-1];
				div_found_s[k] <= div_found_s[k-1];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k] <= 1'b0;
			end else if (ce) begin
				div_v_s[k] <= div_v_s[k-1];
			end
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			v_s5       <= 1'b0;
			v_s6       <= 1'b0;
			v_s7       <= 1'b0;
			v_s8       <= 1'b0;
			v_s9       <= 1'b0;
			div_v_s[0] <= 1'b0;
		end else if (ce) begin
			v_s1       <= in_valid;
			v_s2       <= v_s1;
			v_s3       <= v_s2;
			v_s4       <= v_s3;
			v_s5       <= v_s4;
			v_s6       <= v_s5;
			v_s7       <= v_s6;
			v_s8       <= v_s7;
			v_s9       <= v_s8;
			div_v_s[0] <= v_s9;
		end
	end

	// The last divider stage is the output register.
	assign out_valid         = div_v_s[TW];
	assign out_data.collided = div_found_s[TW];
	assign out_data.hit_time = div_q_s[TW];

	`SWAABB_ASSERT_NXT(a_transfer_fills_s1, clk, arst_n, in_valid && !in_stall, v_s1, "accepted item did not enter stage 1")
	`SWAABB_ASSERT_IMP(a_miss_zero_time, clk, arst_n, out_valid && !out_data.collided, out_data.hit_time == '0, "miss reported nonzero time")
	`SWAABB_ASSERT_IMP(a_output_wait_holds_input, clk, arst_n, out_valid && out_stall, in_stall, "input taken while output result waits")

endmodule

### tb/swept_aabb_time_of_impact_checker.sv
// Checker for the swept box time of impact unit: predicts each result from the
// accepted box pairs and the interval length, and compares. Depends on swaabb_pkg.
module swept_aabb_time_of_impact_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  swaabb_pkg::swaabb_in_t  in_data,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  swaabb_pkg::swaabb_out_t out_data,
	input  logic                    cfg_wr_en,
	input  logic [31:0]             cfg_wr_data,
	output int                      fail_count,
	output int                      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0] interval_len;
	swaabb_pkg::swaabb_out_t impact_q[$];

	// Earliest crossing so far, as numerator over denominator.
	bit            hit_found;
	longint signed best_num, best_den;

	function automatic void cross_edge(longint signed c, longint signed along,
			longint signed across, longint signed lo, longint signed hi);
		longint signed den, num;
		logic signed [127:0] prod;
		if (along == 0)
			return;
		den = along < 0 ? -along : along;
		num = along < 0 ? -c : c;
		if (num < 0 || num > den)
			return;
		prod = 128'(num) * 128'(across);
		if (128'(lo) * 128'(den) > prod || prod > 128'(hi) * 128'(den))
			return;
		if (!hit_found || 128'(num) * 128'(best_den) < 128'(best_num) * 128'(den)) begin
			hit_found = 1;
			best_num = num;
			best_den = den;
		end
	endfunction

	function automatic swaabb_pkg::swaabb_out_t impact_of(swaabb_pkg::swaabb_in_t p);
		longint signed alx, ahx, alz, ahz, blx, bhx, blz, bhz, mx, mz;
		logic [127:0] scaled;
		swaabb_pkg::swaabb_out_t r;
		alx = p.a_low_x < p.a_high_x ? p.a_low_x : p.a_high_x;
		ahx = p.a_low_x < p.a_high_x ? p.a_high_x : p.a_low_x;
		alz = p.a_low_z < p.a_high_z ? p.a_low_z : p.a_high_z;
		ahz = p.a_low_z < p.a_high_z ? p.a_high_z : p.a_low_z;
		blx = p.b_low_x < p.b_high_x ? p.b_low_x : p.b_high_x;
		bhx = p.b_low_x < p.b_high_x ? p.b_high_x : p.b_low_x;
		blz = p.b_low_z < p.b_high_z ? p.b_low_z : p.b_high_z;
		bhz = p.b_low_z < p.b_high_z ? p.b_high_z : p.b_low_z;
		mx = longint'(p.b_move_x) - longint'(p.a_move_x);
		mz = longint'(p.b_move_z) - longint'(p.a_move_z);
		hit_found = 0;
		best_num = 0;
		best_den = 1;
		cross_edge(alx - bhx, mx, mz, alz - bhz, ahz - blz);
		cross_edge(ahx - blx, mx, mz, alz - bhz, ahz - blz);
		cross_edge(alz - bhz, mz, mx, alx - bhx, ahx - blx);
		cross_edge(ahz - blz, mz, mx, alx - bhx, ahx - blx);
		r.collided = hit_found;
		if (hit_found) begin
			scaled = (128'(best_num) * 128'(interval_len)) / 128'(best_den);
			r.hit_time = scaled[31:0];
		end else
			r.hit_time = '0;
		return r;
	endfunction

	assign pending = impact_q.size();

	always @(posedge clk or negedge arst_n) begin
		swaabb_pkg::swaabb_out_t want;
		if (!arst_n) begin
			interval_len <= swaabb_pkg::TOTAL_TIME_RESET;
			fail_count <= 0;
		end else begin
			// Predict with the interval in force before this edge's write.
			if (in_valid && !in_stall)
				impact_q.insert(impact_q.size(), impact_of(in_data));
			if (cfg_wr_en)
				interval_len <= cfg_wr_data;
			if (out_valid && !out_stall) begin
				if (impact_q.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_data);
					fail_count <= fail_count + 1;
				end else begin
					want = impact_q.pop_front();
					if (want.collided !== out_data.collided ||
							want.hit_time !== out_data.hit_time) begin
						$display("%0t: expected collided=%0d hit_time=%h, got %0d %h",
							$time, want.collided, want.hit_time,
							out_data.collided, out_data.hit_time);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

### tb/swept_aabb_time_of_impact_unit_tb.sv
// Testbench top for the swept box time of impact unit: drives box pairs and
// interval writes, varies idling, and reports. Depends on swaabb_pkg, the unit and the checker.
module swept_aabb_time_of_impact_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY   = 42;
	localparam int MAX_CYCLES = 400000;

	logic                    clk = 0;
	logic                    arst_n = 0;
	logic                    in_valid = 0;
	logic                    in_stall;
	swaabb_pkg::swaabb_in_t  in_data = '0;
	logic                    out_valid;
	logic                    out_stall = 0;
	swaabb_pkg::swaabb_out_t out_data;
	logic                    cfg_wr_en = 0;
	logic [31:0]             cfg_wr_data = '0;
	int                      fail_count, pending;

	// Idle percentages for sender and receiver; hold forces a long receiver stall.
	int send_idle = 0, recv_idle = 0;
	bit hold_off = 0;
	int cycle_count = 0;

	always #5 clk = ~clk;

	swept_aabb_time_of_impact_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	swept_aabb_time_of_impact_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.fail_count(fail_count), .pending(pending)
	);

	// Receiver: stall at random, or solidly while held off.
	always @(negedge clk)
		out_stall <= hold_off || ($urandom_range(99) < recv_idle);

	// Watchdog: bail out on a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offer one pair, with random gaps first, then hold it until the transfer.
	// Valid stays up after the transfer; a random gap before the next pair or an idle drops it.
	task automatic send_pair(swaabb_pkg::swaabb_in_t p);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		in_data <= p;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	function automatic logic [31:0] any_word();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($signed($urandom_range(8)) - 4) << 16;
			default: return $urandom;
		endcase
	endfunction

	// Mostly modest boxes with larger random motion so edges actually get hit.
	function automatic swaabb_pkg::swaabb_in_t random_pair();
		swaabb_pkg::swaabb_in_t p;
		int unsigned sc;
		if ($urandom_range(9) < 2) begin
			p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			if ($urandom_range(1)) p.a_low_x = any_word();
			if ($urandom_range(1)) p.b_move_z = any_word();
			return p;
		end
		sc = $urandom_range(20, 4);
		p.a_low_x  = $signed($urandom) >>> sc;
		p.a_low_z  = $signed($urandom) >>> sc;
		p.a_high_x = $signed($urandom) >>> sc;
		p.a_high_z = $signed($urandom) >>> sc;
		p.b_low_x  = $signed($urandom) >>> sc;
		p.b_low_z  = $signed($urandom) >>> sc;
		p.b_high_x = $signed($urandom) >>> sc;
		p.b_high_z = $signed($urandom) >>> sc;
		p.a_move_x = $signed($urandom) >>> (sc - 2);
		p.a_move_z = $signed($urandom) >>> (sc - 2);
		p.b_move_x = $signed($urandom) >>> (sc - 2);
		p.b_move_z = $signed($urandom) >>> (sc - 2);
		if ($urandom_range(7) == 0) p.b_move_x = p.a_move_x;
		if ($urandom_range(7) == 0) p.b_move_z = p.a_move_z;
		return p;
	endfunction

	// Build a pair from unit-scaled coordinates (Q16.16 integers).
	function automatic swaabb_pkg::swaabb_in_t unit_pair(int alx, int alz, int ahx,
			int ahz, int blx, int blz, int bhx, int bhz, int amx, int amz, int bmx,
			int bmz);
		return {alx << 16, alz << 16, ahx << 16, ahz << 16, blx << 16, blz << 16,
			bhx << 16, bhz << 16, amx << 16, amz << 16, bmx << 16, bmz << 16};
	endfunction

	// Write the interval only while idle, once the results have drained.
	task automatic set_interval(logic [31:0] v);
		in_valid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		cfg_wr_en <= 1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 0;
	endtask

	initial begin
		swaabb_pkg::swaabb_in_t p;
		repeat (8) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed: A at rest, B approaching along x from the right.
		send_pair(unit_pair(0, 0, 1, 1, 3, 0, 4, 1, 0, 0, -4, 0));
		// Swapped corners of the same case.
		send_pair(unit_pair(1, 1, 0, 0, 4, 1, 3, 0, 0, 0, -4, 0));
		// Zero relative motion: both move the same.
		send_pair(unit_pair(0, 0, 1, 1, 3, 0, 4, 1, 2, 5, 2, 5));
		// Touching at the start.
		send_pair(unit_pair(0, 0, 1, 1, 1, 0, 2, 1, 0, 0, -1, 0));
		// Overlap at the start: exit crossing.
		send_pair(unit_pair(0, 0, 2, 2, 1, 1, 3, 3, 0, 0, 1, 1));
		// Contact exactly at t = 1.
		send_pair(unit_pair(0, 0, 1, 1, 3, 0, 4, 1, 0, 0, -2, 0));
		// Corner to corner on a diagonal: an x edge and a z edge give equal crossings.
		send_pair(unit_pair(0, 0, 1, 1, 2, 2, 3, 3, 0, 0, -1, -1));
		// One just misses past an edge end, the next hits; motion along z only.
		send_pair(unit_pair(0, 0, 1, 1, 2, 3, 3, 4, 0, 0, 0, -4));
		send_pair(unit_pair(0, 0, 1, 1, 0, 3, 1, 4, 0, 0, 0, -4));
		// Moving away: no hit.
		send_pair(unit_pair(0, 0, 1, 1, 3, 0, 4, 1, 0, 0, 4, 0));
		// Extremes of every field.
		send_pair({12{32'h8000_0000}});
		send_pair({12{32'h7fff_ffff}});
		send_pair({32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff});
		send_pair('0);
		send_pair({12{32'hffff_ffff}});

		// Interval extremes on a fixed hit.
		set_interval(32'hffff_ffff);
		send_pair(unit_pair(0, 0, 1, 1, 3, 0, 4, 1, 0, 0, -3, 0));
		send_pair(unit_pair(0, 0, 1, 1, 1, 0, 2, 1, 0, 0, -7, 0));
		set_interval(32'h0);
		send_pair(unit_pair(0, 0, 1, 1, 3, 0, 4, 1, 0, 0, -3, 0));
		set_interval(32'd1);
		send_pair(unit_pair(0, 0, 1, 1, 3, 0, 4, 1, 0, 0, -3, 0));

		// Random phases: receiver-heavy idling, sender-heavy, then none.
		for (int ph = 0; ph < 3; ph++) begin
			set_interval(ph == 0 ? 32'h0001_8000 : ph == 1 ? $urandom : 32'h0000_4000);
			send_idle = ph == 0 ? 14 : ph == 1 ? 46 : 0;
			recv_idle = ph == 0 ? 46 : ph == 1 ? 14 : 0;
			for (int i = 0; i < 180; i++) begin
				// Hold off the receiver for a long stretch in the last phase.
				if (ph == 2 && i == 20)
					fork
						begin
							hold_off = 1;
							repeat (150) @(negedge clk);
							hold_off = 0;
						end
					join_none
				p = random_pair();
				send_pair(p);
			end
		end

		in_valid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
